// ----- design/cron_next_match_time_assert.svh -----
// Assertion macros for the cron next-match block.
`ifndef CRON_NEXT_MATCH_TIME_ASSERT_SVH
`define CRON_NEXT_MATCH_TIME_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define CNMT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define CNMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/cnmt_pkg.sv -----
// Types, constants and helper functions shared by the cron next-match block.
`default_nettype none
package cnmt_pkg;

  localparam int unsigned CNMT_YEAR_LIMIT_DEF = 2099;

  typedef enum logic [2:0] {
    REG_MINUTE_MASK  = 3'd0,
    REG_HOUR_MASK    = 3'd1,
    REG_DAY_MASK     = 3'd2,
    REG_MONTH_MASK   = 3'd3,
    REG_WEEKDAY_MASK = 3'd4,
    REG_YEAR_FIRST   = 3'd5,
    REG_YEAR_LAST    = 3'd6,
    REG_YEAR_STEP    = 3'd7
  } cnmt_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEARS,
    ST_MONTHS,
    ST_DAYS,
    ST_DONE
  } cnmt_state_e;

  typedef struct packed {
    logic [11:0] now_year;
    logic [3:0]  now_month;
    logic [4:0]  now_day;
    logic [4:0]  now_hour;
    logic [5:0]  now_minute;
  } cnmt_req_t;

  typedef struct packed {
    logic        found;
    logic [11:0] next_year;
    logic [3:0]  next_month;
    logic [4:0]  next_day;
    logic [4:0]  next_hour;
    logic [5:0]  next_minute;
  } cnmt_res_t;

  typedef struct packed {
    logic [59:0] minute_mask;
    logic [23:0] hour_mask;
    logic [30:0] day_mask;
    logic [11:0] month_mask;
    logic [6:0]  weekday_mask;
    logic [11:0] year_first;
    logic [11:0] year_last;
    logic [11:0] year_step;
  } cnmt_cfg_t;

  typedef struct packed {
    logic load;
    logic year_adv;
    logic month_adv;
    logic day_enter;
    logic day_adv;
    logic cap_found;
    logic cap_none;
  } cnmt_cmd_t;

  typedef struct packed {
    logic y_eq_now;
    logic y_over_top;
    logic masks_empty;
    logic month_skip;
    logic day_over;
    logic day_hit;
  } cnmt_sts_t;

  // Weekday of January 1st of year 0, proleptic Gregorian (Saturday).
  localparam logic [2:0] WdYear0 = 3'd6;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd2:                      n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] mod7(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    if (r >= 6'd28) r = r - 6'd28;
    if (r >= 6'd14) r = r - 6'd14;
    if (r >= 6'd7)  r = r - 6'd7;
    return r[2:0];
  endfunction

endpackage
`default_nettype wire

// ----- design/cnmt_ctrl.sv -----
// Controller for the calendar walk: years, then months, then days.
`default_nettype none
module cnmt_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  input  cnmt_pkg::cnmt_sts_t     sts_i,
  output cnmt_pkg::cnmt_cmd_t     cmd_o,
  output logic                    busy,
  output logic                    valid_o
);
  import cnmt_pkg::*;

  cnmt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_YEARS;
      end
      ST_YEARS: begin
        if (sts_i.masks_empty || sts_i.y_over_top) state_d = ST_DONE;
        else if (sts_i.y_eq_now)                   state_d = ST_MONTHS;
      end
      ST_MONTHS: begin
        if (sts_i.y_over_top)       state_d = ST_DONE;
        else if (!sts_i.month_skip) state_d = ST_DAYS;
      end
      ST_DAYS: begin
        if (sts_i.day_over)     state_d = ST_MONTHS;
        else if (sts_i.day_hit) state_d = ST_DONE;
      end
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o   = '0;
    busy    = (state_q != ST_IDLE);
    valid_o = (state_q == ST_DONE);
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = start;
      end
      ST_YEARS: begin
        if (sts_i.masks_empty || sts_i.y_over_top) cmd_o.cap_none = 1'b1;
        else if (!sts_i.y_eq_now)                  cmd_o.year_adv = 1'b1;
      end
      ST_MONTHS: begin
        if (sts_i.y_over_top)      cmd_o.cap_none  = 1'b1;
        else if (sts_i.month_skip) cmd_o.month_adv = 1'b1;
        else                       cmd_o.day_enter = 1'b1;
      end
      ST_DAYS: begin
        if (sts_i.day_over)     cmd_o.month_adv = 1'b1;
        else if (sts_i.day_hit) cmd_o.cap_found = 1'b1;
        else                    cmd_o.day_adv   = 1'b1;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- design/cnmt_dp.sv -----
// Datapath: calendar counters, weekday tracking and hour/minute pick.
`default_nettype none
module cnmt_dp #(
  parameter int unsigned YEAR_LIMIT = cnmt_pkg::CNMT_YEAR_LIMIT_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  cnmt_pkg::cnmt_req_t     req_i,
  input  cnmt_pkg::cnmt_cfg_t     cfg_i,
  input  cnmt_pkg::cnmt_cmd_t     cmd_i,
  output cnmt_pkg::cnmt_sts_t     sts_o,
  output cnmt_pkg::cnmt_res_t     res_o
);
  import cnmt_pkg::*;

  localparam logic [11:0] TopMax = 12'(YEAR_LIMIT - 1);

  cnmt_req_t   now_q;
  cnmt_res_t   res_q;
  logic [11:0] y_q, rs_q;
  logic [6:0]  c100_q;
  logic [8:0]  c400_q;
  logic [2:0]  wd1_q, wd_q;
  logic [3:0]  m_q;
  logic [5:0]  d_q;

  logic [11:0] top, step_eff, rs_inc;
  logic        leap, ty, tm, td, yvalid;
  logic [4:0]  dim;
  logic [5:0]  d0;

  assign top      = (cfg_i.year_last > TopMax) ? TopMax : cfg_i.year_last;
  assign step_eff = (cfg_i.year_step == 12'd0) ? 12'd1 : cfg_i.year_step;
  assign rs_inc   = rs_q + 12'd1;
  assign leap     = (y_q[1:0] == 2'd0) && ((c100_q != 7'd0) || (c400_q == 9'd0));
  assign dim      = month_len(m_q, leap);
  assign ty       = (y_q == now_q.now_year);
  assign tm       = ty && (m_q == now_q.now_month);
  assign td       = tm && (d_q == {1'b0, now_q.now_day});
  assign yvalid   = (y_q >= cfg_i.year_first) && (rs_q == 12'd0);
  assign d0       = (tm && (now_q.now_day > 5'd1)) ? {1'b0, now_q.now_day} : 6'd1;

  // Hour and minute pick for the current day.
  logic [59:0] min_tight;
  logic [23:0] hr_cand;
  logic [5:0]  mt, ma;
  logic        mt_v;
  logic [4:0]  ha;
  logic        ha_v, nh_ok, hm_hit;

  always_comb begin
    for (int i = 0; i < 60; i++) begin
      min_tight[i] = cfg_i.minute_mask[i] && (6'(i) > now_q.now_minute);
    end
    for (int i = 0; i < 24; i++) begin
      hr_cand[i] = cfg_i.hour_mask[i] && (!td || (5'(i) > now_q.now_hour));
    end
    mt = '0; mt_v = 1'b0; ma = '0; ha = '0; ha_v = 1'b0;
    for (int i = 59; i >= 0; i--) begin
      if (min_tight[i]) begin
        mt = 6'(i); mt_v = 1'b1;
      end
      if (cfg_i.minute_mask[i]) ma = 6'(i);
    end
    for (int i = 23; i >= 0; i--) begin
      if (hr_cand[i]) begin
        ha = 5'(i); ha_v = 1'b1;
      end
    end
  end

  assign nh_ok  = td && (now_q.now_hour < 5'd24) && cfg_i.hour_mask[now_q.now_hour] && mt_v;
  assign hm_hit = nh_ok || ha_v;

  assign sts_o.y_eq_now    = ty;
  assign sts_o.y_over_top  = (y_q > top);
  assign sts_o.masks_empty = (cfg_i.minute_mask == '0) || (cfg_i.hour_mask == '0);
  assign sts_o.month_skip  = !yvalid || (ty && (m_q < now_q.now_month))
                             || !cfg_i.month_mask[m_q - 4'd1];
  assign sts_o.day_over    = (d_q > {1'b0, dim});
  assign sts_o.day_hit     = cfg_i.day_mask[5'(d_q - 6'd1)] && cfg_i.weekday_mask[wd_q]
                             && hm_hit;

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q  <= '0;
      res_q  <= '0;
      y_q    <= '0;
      rs_q   <= '0;
      c100_q <= '0;
      c400_q <= '0;
      wd1_q  <= WdYear0;
      wd_q   <= '0;
      m_q    <= 4'd1;
      d_q    <= 6'd1;
    end else begin
      if (cmd_i.load) begin
        now_q  <= req_i;
        y_q    <= '0;
        rs_q   <= '0;
        c100_q <= '0;
        c400_q <= '0;
        wd1_q  <= WdYear0;
        m_q    <= 4'd1;
      end
      if (cmd_i.year_adv || (cmd_i.month_adv && (m_q == 4'd12))) begin
        y_q    <= y_q + 12'd1;
        rs_q   <= (rs_inc == step_eff) ? 12'd0 : rs_inc;
        c100_q <= (c100_q == 7'd99) ? 7'd0 : c100_q + 7'd1;
        c400_q <= (c400_q == 9'd399) ? 9'd0 : c400_q + 9'd1;
      end
      if (cmd_i.year_adv) begin
        wd1_q <= mod7(6'(wd1_q) + 6'd1 + 6'(leap));
      end
      if (cmd_i.month_adv) begin
        wd1_q <= mod7(6'(wd1_q) + 6'(dim - 5'd28));
        m_q   <= (m_q == 4'd12) ? 4'd1 : m_q + 4'd1;
      end
      if (cmd_i.day_enter) begin
        d_q  <= d0;
        wd_q <= mod7(6'(wd1_q) + d0 - 6'd1);
      end
      if (cmd_i.day_adv) begin
        d_q  <= d_q + 6'd1;
        wd_q <= (wd_q == 3'd6) ? 3'd0 : wd_q + 3'd1;
      end
      if (cmd_i.cap_found) begin
        res_q.found       <= 1'b1;
        res_q.next_year   <= y_q;
        res_q.next_month  <= m_q;
        res_q.next_day    <= d_q[4:0];
        res_q.next_hour   <= nh_ok ? now_q.now_hour : ha;
        res_q.next_minute <= nh_ok ? mt : ma;
      end
      if (cmd_i.cap_none) begin
        res_q <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/cron_next_match_time.sv -----
// Top level of the cron next-match block: schedule registers, controller and datapath.
//
// A request (start high while busy is low) carries the current calendar minute.
// The block answers with exactly one result: valid_o is high for one cycle and
// res_o then holds the earliest later minute that matches the schedule, or
// found = 0 with all fields zero. The receiver cannot stall the result, so
// sample it in the cycle valid_o is high. busy stays high from the request to
// the result cycle. The search is a walk through the calendar, one step per
// cycle: first the years from year 0 up to the requested year (to build the
// weekday and leap counters without dividers), then the months, and then the
// days inside allowed months of allowed years. The search takes longest for a
// requested year far below the allowed range, walked month by month, then a
// full search with no match.
// Schedule writes go through the cfg port and must only happen while busy is low.
`default_nettype none
module cron_next_match_time #(
  parameter int unsigned YEAR_LIMIT = cnmt_pkg::CNMT_YEAR_LIMIT_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  cnmt_pkg::cnmt_req_t     req_i,
  output logic                    valid_o,
  output cnmt_pkg::cnmt_res_t     res_o,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [59:0]        cfg_data_i
);
  import cnmt_pkg::*;

  cnmt_cfg_t cfg_q;
  cnmt_cmd_t cmd;
  cnmt_sts_t sts;

  // Schedule registers; reset allows every minute of every year in range.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.minute_mask  <= '1;
      cfg_q.hour_mask    <= '1;
      cfg_q.day_mask     <= '1;
      cfg_q.month_mask   <= '1;
      cfg_q.weekday_mask <= '1;
      cfg_q.year_first   <= 12'd1970;
      cfg_q.year_last    <= 12'd2099;
      cfg_q.year_step    <= 12'd1;
    end else if (cfg_we_i) begin
      unique case (cnmt_reg_e'(cfg_idx_i))
        REG_MINUTE_MASK:  cfg_q.minute_mask  <= cfg_data_i;
        REG_HOUR_MASK:    cfg_q.hour_mask    <= cfg_data_i[23:0];
        REG_DAY_MASK:     cfg_q.day_mask     <= cfg_data_i[30:0];
        REG_MONTH_MASK:   cfg_q.month_mask   <= cfg_data_i[11:0];
        REG_WEEKDAY_MASK: cfg_q.weekday_mask <= cfg_data_i[6:0];
        REG_YEAR_FIRST:   cfg_q.year_first   <= cfg_data_i[11:0];
        REG_YEAR_LAST:    cfg_q.year_last    <= cfg_data_i[11:0];
        REG_YEAR_STEP:    cfg_q.year_step    <= cfg_data_i[11:0];
        default: begin
        end
      endcase
    end
  end

  // Sequence the walk: years, months, days, then the result strobe.
  cnmt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy    (busy),
    .valid_o (valid_o)
  );

  // Hold the calendar position, weekday and the captured result.
  cnmt_dp #(
    .YEAR_LIMIT (YEAR_LIMIT)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cfg_i  (cfg_q),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (res_o)
  );

`include "cron_next_match_time_assert.svh"

  `CNMT_ASSERT_IMPL(a_strobe_busy, valid_o, busy, "result strobe outside a request")
  `CNMT_ASSERT_NEXT(a_start_busy, start && !busy, busy, "request not taken")
  `CNMT_ASSERT_IMPL(a_none_zero, valid_o && !res_o.found,
                    res_o == '0, "not-found result carries data")
  `CNMT_ASSERT_IMPL(a_found_range, valid_o && res_o.found,
                    (res_o.next_minute < 6'd60) && (res_o.next_hour < 5'd24)
                    && (res_o.next_month != 4'd0) && (res_o.next_month < 4'd13),
                    "found result out of calendar range")

endmodule
`default_nettype wire

// ----- tb/sv/cron_next_match_time_tb.sv -----
// Testbench for cron_next_match_time: random and directed requests, self-checking.
`default_nettype none
module cron_next_match_time_tb;
  import cnmt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Bound for the whole run: several times the slowest correct request walk,
  // for roughly 130 requests plus idle gaps.
  localparam int unsigned CycleLimit = 40_000_000;
  localparam int unsigned YearCap    = CNMT_YEAR_LIMIT_DEF;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  cnmt_req_t   req_i = '0;
  logic        valid_o;
  cnmt_res_t   res_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [59:0] cfg_data_i = '0;

  cron_next_match_time DUT (
    .clk_i, .rst_ni, .start, .busy, .req_i, .valid_o, .res_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #2 clk_i = ~clk_i;

  // Local copy of the schedule, kept in step with every register write.
  cnmt_cfg_t sched;

  cnmt_req_t pend_q[$];    // requests waiting for the driver
  cnmt_res_t fire_q[$];    // predicted next-fire times, oldest first
  int unsigned idle_pct = 0;
  int unsigned cycles = 0;
  bit failed = 0;
  logic took = 1'b0;       // request accepted at the last rising edge

  function automatic bit leap_year(int unsigned y);
    return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
  endfunction

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    case (m)
      2:            return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:  return 30;
      default:      return 31;
    endcase
  endfunction

  // Weekday with 0 as Sunday; shift by 400 years so January/February never underflow.
  function automatic int unsigned day_of_week(int unsigned y, int unsigned m, int unsigned d);
    int unsigned off[12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
    int unsigned yy;
    yy = y + 400;
    if (m < 3) yy = yy - 1;
    return (yy + yy / 4 - yy / 100 + yy / 400 + off[m - 1] + d) % 7;
  endfunction

  // Earliest allowed minute strictly after 'after' when tight; 64 if none.
  function automatic int unsigned first_minute(bit tight, int unsigned after);
    logic [63:0] cand;
    logic [63:0] low;
    cand = {4'b0, sched.minute_mask};
    if (tight) begin
      low = (64'd2 << (after & 63)) - 64'd1;
      cand = cand & ~low;
    end
    for (int i = 0; i < 60; i++) begin
      if (cand[i]) return i;
    end
    return 64;
  endfunction

  function automatic cnmt_res_t next_fire(cnmt_req_t q);
    cnmt_res_t r;
    int unsigned stp, top, mi;
    bit ty, tm, td, th;
    r = '0;
    stp = (sched.year_step == 0) ? 1 : sched.year_step;
    top = sched.year_last;
    if (sched.minute_mask == 0 || sched.hour_mask == 0) return r;
    if (top > YearCap - 1) top = YearCap - 1;
    for (int unsigned y = q.now_year; y <= top; y++) begin
      ty = (y == q.now_year);
      if (y < sched.year_first || y % stp != 0) continue;
      for (int unsigned m = 1; m <= 12; m++) begin
        tm = ty && m == q.now_month;
        if (ty && m < q.now_month) continue;
        if (!sched.month_mask[m - 1]) continue;
        for (int unsigned d = 1; d <= month_days(y, m); d++) begin
          td = tm && d == q.now_day;
          if (tm && d < q.now_day) continue;
          if (!sched.day_mask[d - 1]) continue;
          if (!sched.weekday_mask[day_of_week(y, m, d)]) continue;
          for (int unsigned h = 0; h < 24; h++) begin
            th = td && h == q.now_hour;
            if (td && h < q.now_hour) continue;
            if (!sched.hour_mask[h]) continue;
            mi = first_minute(th, q.now_minute);
            if (mi < 60) begin
              r.found = 1'b1;
              r.next_year = y[11:0];
              r.next_month = m[3:0];
              r.next_day = d[4:0];
              r.next_hour = h[4:0];
              r.next_minute = mi[5:0];
              return r;
            end
          end
        end
      end
    end
    return r;
  endfunction

  // Driver: change inputs at the falling edge only.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start && !took) begin
        // hold the request until the block takes it
      end else if (pend_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        req_i <= pend_q.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: sample at the rising edge, predict on acceptance, check on valid.
  always @(posedge clk_i) begin
    cnmt_res_t exp_r;
    cycles <= cycles + 1;
    took <= start && !busy && rst_ni;
    if (rst_ni && start && !busy) fire_q.push_back(next_fire(req_i));
    if (rst_ni && valid_o) begin
      if (fire_q.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, res_o);
        failed = 1;
      end else begin
        exp_r = fire_q.pop_front();
        if (res_o.found !== exp_r.found) begin
          $display("%0t: found exp %0d got %0d", $realtime, exp_r.found, res_o.found);
          failed = 1;
        end
        if (res_o.next_year !== exp_r.next_year) begin
          $display("%0t: year exp %0d got %0d", $realtime, exp_r.next_year, res_o.next_year);
          failed = 1;
        end
        if (res_o.next_month !== exp_r.next_month) begin
          $display("%0t: month exp %0d got %0d", $realtime, exp_r.next_month,
                   res_o.next_month);
          failed = 1;
        end
        if (res_o.next_day !== exp_r.next_day) begin
          $display("%0t: day exp %0d got %0d", $realtime, exp_r.next_day, res_o.next_day);
          failed = 1;
        end
        if (res_o.next_hour !== exp_r.next_hour) begin
          $display("%0t: hour exp %0d got %0d", $realtime, exp_r.next_hour, res_o.next_hour);
          failed = 1;
        end
        if (res_o.next_minute !== exp_r.next_minute) begin
          $display("%0t: minute exp %0d got %0d", $realtime, exp_r.next_minute,
                   res_o.next_minute);
          failed = 1;
        end
      end
    end
  end

  // Watchdog: give up on a hung block.
  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Write one register at the falling edge and mirror it; the caller drops the enable.
  task automatic write_reg(cnmt_reg_e idx, logic [59:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_MINUTE_MASK:  sched.minute_mask = val;
      REG_HOUR_MASK:    sched.hour_mask = val[23:0];
      REG_DAY_MASK:     sched.day_mask = val[30:0];
      REG_MONTH_MASK:   sched.month_mask = val[11:0];
      REG_WEEKDAY_MASK: sched.weekday_mask = val[6:0];
      REG_YEAR_FIRST:   sched.year_first = val[11:0];
      REG_YEAR_LAST:    sched.year_last = val[11:0];
      REG_YEAR_STEP:    sched.year_step = val[11:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Load the whole schedule: all five masks, the year range and the step.
  task automatic load_sched(logic [59:0] mm, logic [23:0] hm, logic [30:0] dm,
                            logic [11:0] mo, logic [6:0] wm,
                            int unsigned yf, int unsigned yl, int unsigned ys);
    write_reg(REG_MINUTE_MASK, mm);
    write_reg(REG_HOUR_MASK, {36'b0, hm});
    write_reg(REG_DAY_MASK, {29'b0, dm});
    write_reg(REG_MONTH_MASK, {48'b0, mo});
    write_reg(REG_WEEKDAY_MASK, {53'b0, wm});
    write_reg(REG_YEAR_FIRST, 60'(yf));
    write_reg(REG_YEAR_LAST, 60'(yl));
    write_reg(REG_YEAR_STEP, 60'(ys));
    end_writes();
  endtask

  function automatic cnmt_req_t make_req(int unsigned y, int unsigned mo, int unsigned d,
                                         int unsigned h, int unsigned mi);
    cnmt_req_t q;
    q.now_year = y[11:0];
    q.now_month = mo[3:0];
    q.now_day = d[4:0];
    q.now_hour = h[4:0];
    q.now_minute = mi[5:0];
    return q;
  endfunction

  // Mostly real calendar minutes; some raw bit patterns to reach out-of-range fields.
  function automatic cnmt_req_t rand_req();
    if ($urandom_range(9) == 0) return cnmt_req_t'($urandom);
    return make_req($urandom_range(1970, 2098), $urandom_range(1, 12), $urandom_range(1, 31),
                    $urandom_range(0, 23), $urandom_range(0, 59));
  endfunction

  // Let every outstanding request come back before touching the schedule.
  task automatic drain();
    do @(negedge clk_i); while (pend_q.size() != 0 || start || fire_q.size() != 0);
  endtask

  task automatic run_random(int unsigned n, int unsigned pct);
    idle_pct = pct;
    repeat (n) pend_q.push_back(rand_req());
    drain();
  endtask

  initial begin
    sched = '{minute_mask: '1, hour_mask: '1, day_mask: '1, month_mask: '1,
              weekday_mask: '1, year_first: 12'd1970, year_last: 12'd2099,
              year_step: 12'd1};
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests against the reset schedule: field extremes, leap days,
    // end of search range and out-of-range calendar fields.
    idle_pct = 0;
    pend_q.push_back(make_req(1970, 1, 1, 0, 0));
    pend_q.push_back(make_req(2098, 12, 31, 23, 59));   // nothing before the year limit
    pend_q.push_back(make_req(2099, 6, 15, 12, 30));
    pend_q.push_back(make_req(4095, 15, 31, 31, 63));   // all input bits high
    pend_q.push_back(make_req(0, 0, 0, 0, 0));          // all input bits low
    pend_q.push_back(make_req(2000, 2, 28, 23, 59));    // century leap year
    pend_q.push_back(make_req(2023, 2, 28, 23, 59));
    pend_q.push_back(make_req(2024, 2, 29, 23, 59));
    pend_q.push_back(make_req(2021, 13, 1, 0, 0));      // month past December
    pend_q.push_back(make_req(2021, 2, 31, 0, 0));      // day past month end
    pend_q.push_back(make_req(2021, 5, 10, 24, 0));     // hour past 23
    pend_q.push_back(make_req(2021, 5, 10, 7, 60));     // minute past 59
    pend_q.push_back(make_req(2021, 12, 31, 23, 58));
    pend_q.push_back(make_req(1999, 12, 31, 23, 59));
    drain();

    // Sparse extremes: only minute 59, hour 23, day 31, December; step 0 acts as 1.
    load_sched(60'd1 << 59, 24'd1 << 23, 31'd1 << 30, 12'h800, 7'h7F, 1970, 2099, 0);
    pend_q.push_back(make_req(2030, 12, 31, 23, 58));
    pend_q.push_back(make_req(2030, 12, 31, 23, 59));
    pend_q.push_back(make_req(1970, 1, 1, 0, 0));
    drain();

    // Only minute 0, hour 0, day 1, January, Sundays; years every fourth from 2020 to 2060.
    load_sched(60'd1, 24'd1, 31'd1, 12'h001, 7'h01, 2020, 2060, 4);
    pend_q.push_back(make_req(1970, 1, 1, 0, 0));
    pend_q.push_back(make_req(2040, 1, 1, 0, 0));
    pend_q.push_back(make_req(2060, 1, 1, 0, 0));
    drain();

    // Empty searches: no weekday allowed, an inverted year range, a step with no
    // multiple below the limit, and empty minute and hour masks.
    load_sched('1, '1, '1, '1, 7'h00, 1970, 2099, 1);
    pend_q.push_back(make_req(2090, 1, 1, 0, 0));
    drain();
    load_sched('1, '1, '1, '1, 7'h7F, 2080, 2050, 1);
    pend_q.push_back(make_req(2040, 3, 3, 3, 3));
    drain();
    load_sched('1, '1, '1, '1, 7'h7F, 1970, 2099, 2099);
    pend_q.push_back(make_req(2095, 3, 3, 3, 3));
    drain();
    load_sched('0, '1, '1, '1, 7'h7F, 1970, 2099, 1);
    pend_q.push_back(make_req(2010, 3, 3, 3, 3));
    drain();
    load_sched('1, '0, '1, '1, 7'h7F, 4095, 4095, 4095);
    pend_q.push_back(make_req(2010, 3, 3, 3, 3));
    drain();

    // Random traffic across idle phases with fresh random schedules.
    for (int ph = 0; ph < 4; ph++) begin
      load_sched(60'({$urandom, $urandom}) | (60'd1 << $urandom_range(59)),
                 24'($urandom) | (24'd1 << $urandom_range(23)),
                 31'($urandom) | 31'h0FFF_FFFF,
                 12'($urandom) | (12'd1 << $urandom_range(11)),
                 7'($urandom) | 7'h41,
                 $urandom_range(1970, 2030), $urandom_range(2040, 2099),
                 $urandom_range(1, 3));
      run_random(25, (ph == 1) ? 80 : (ph == 2) ? 31 : 0);
    end

    repeat (200) @(negedge clk_i);
    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
+incdir+design
design/cnmt_pkg.sv
design/cnmt_ctrl.sv
design/cnmt_dp.sv
design/cron_next_match_time.sv
tb/sv/cron_next_match_time_tb.sv
